// ----- rtl/sbptf_pkg.sv -----
// ----------------------------------------------------------------------------
// Six-bit printable telemetry framer: shared package
// Types, character constants and the frame length used by the front part,
// the job queue and the character sequencer.
// ----------------------------------------------------------------------------
package sbptf_pkg;

   // Number of three-sample groups in one frame.
   localparam logic [3:0] GROUPS_PER_FRAME = 4'd12;

   // Printable offset for the six-bit digits and the framing characters.
   localparam logic [7:0] CH_BASE  = 8'd65;
   localparam logic [7:0] CH_O     = 8'd79;
   localparam logic [7:0] CH_U     = 8'd85;
   localparam logic [7:0] CH_T     = 8'd84;
   localparam logic [7:0] CH_Z     = 8'd90;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;

   // Length of the header and of the trailer in characters.
   localparam logic [3:0] HDR_LEN  = 4'd3;
   localparam logic [3:0] TRL_LEN  = 4'd5;

   // Position of a sample within its group of three.
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // One classified sample: what the sequencer has to emit for it.
   typedef struct packed {
      logic       hdr;     // frame header precedes the digits
      logic       trl;     // frame trailer follows the digits
      logic       three;   // three digits, otherwise two
      logic [5:0] d0;
      logic [5:0] d1;
      logic [5:0] d2;
   } job_type;

endpackage

// ----- rtl/sbptf_front.sv -----
// ----------------------------------------------------------------------------
// Six-bit printable telemetry framer: front part
// Accepts samples, tracks the group phase, group count and carried bits, and
// cuts each sample into the digits and framing flags of one job.
// ----------------------------------------------------------------------------
module sbptf_front
   import sbptf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [15:0] req_sample,
   input  logic              q_full,
   output logic              push,
   output job_type           job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] count_ff, count_in;
   logic [3:0] carry_ff, carry_in;
   logic [15:0] s;

   assign s         = req_sample;
   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   // Classify the sample and work out the next group state.
   always_comb begin
      job      = '0;
      phase_in = phase_ff;
      count_in = count_ff;
      carry_in = carry_ff;
      case (phase_ff)
         PH_SECOND: begin
            job.three = 1'b1;
            job.d0    = {carry_ff, s[15:14]};
            job.d1    = s[13:8];
            job.d2    = s[7:2];
            carry_in  = {2'b00, s[1:0]};
            phase_in  = PH_THIRD;
         end
         PH_THIRD: begin
            job.three = 1'b1;
            job.d0    = {carry_ff[1:0], s[15:12]};
            job.d1    = s[11:6];
            job.d2    = s[5:0];
            carry_in  = 4'd0;
            phase_in  = PH_FIRST;
            if (count_ff >= GROUPS_PER_FRAME - 4'd1) begin
               job.trl  = 1'b1;
               count_in = 4'd0;
            end else begin
               count_in = count_ff + 4'd1;
            end
         end
         default: begin
            job.hdr   = (count_ff == 4'd0);
            job.d0    = s[15:10];
            job.d1    = s[9:4];
            carry_in  = s[3:0];
            phase_in  = PH_SECOND;
         end
      endcase
   end

   // Group state advances on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         count_ff <= 4'd0;
         carry_ff <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         carry_ff <= carry_in;
      end
   end

   // The carry from the second sample of a group is only two bits wide.
   a_carry_narrow: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_THIRD) |-> (carry_ff[3:2] == 2'b00))
      else $error("carry holds more than two bits before the third sample");

   // A frame header and trailer never belong to the same sample.
   a_hdr_trl: assert property (@(posedge clock) disable iff (reset)
      push |-> !(job.hdr && job.trl))
      else $error("header and trailer on one item");

endmodule

// ----- rtl/sbptf_queue.sv -----
// ----------------------------------------------------------------------------
// Six-bit printable telemetry framer: job queue
// Two-entry queue between the front part and the character sequencer, so
// that each side stalls on its own.
// ----------------------------------------------------------------------------
module sbptf_queue
   import sbptf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    mem_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_job   = mem_ff[rd_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("pop from an empty queue");

endmodule

// ----- rtl/sbptf_back.sv -----
// ----------------------------------------------------------------------------
// Six-bit printable telemetry framer: character sequencer
// Steps through the header, digits and trailer of the job at the queue head,
// one character per cycle unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module sbptf_back
   import sbptf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_item,
   output logic       rsp_end_of_frame
);

   logic [2:0] step_ff;
   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       eof_ff;

   logic [3:0] step;
   logic [3:0] hlen;
   logic [3:0] dlen;
   logic [3:0] total;
   logic [3:0] pos;
   logic [7:0] char_in;
   logic       last_in;
   logic       eof_in;
   logic       load;

   assign step  = {1'b0, step_ff};
   assign hlen  = head_job.hdr ? HDR_LEN : 4'd0;
   assign dlen  = head_job.three ? 4'd3 : 4'd2;
   assign total = hlen + dlen + (head_job.trl ? TRL_LEN : 4'd0);
   assign load  = head_valid && (!valid_ff || rsp_ready);
   assign pop   = load && last_in;

   // Pick the character for the current step of the job.
   always_comb begin
      char_in = CH_BASE;
      eof_in  = 1'b0;
      pos     = 4'd0;
      last_in = (step == total - 4'd1);
      if (step < hlen) begin
         case (step[1:0])
            2'd0:    char_in = CH_O;
            2'd1:    char_in = CH_U;
            default: char_in = CH_T;
         endcase
      end else if (step < hlen + dlen) begin
         pos = step - hlen;
         case (pos[1:0])
            2'd0:    char_in = CH_BASE + {2'b00, head_job.d0};
            2'd1:    char_in = CH_BASE + {2'b00, head_job.d1};
            default: char_in = CH_BASE + {2'b00, head_job.d2};
         endcase
      end else begin
         pos = step - hlen - dlen;
         case (pos[2:0])
            3'd3:    char_in = CH_LF;
            3'd4: begin
               char_in = CH_CR;
               eof_in  = 1'b1;
            end
            default: char_in = CH_Z;
         endcase
      end
   end

   // Step counter within the current job.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else if (load) begin
         step_ff <= last_in ? 3'd0 : step_ff + 3'd1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
         eof_ff  <= eof_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_end_of_frame = eof_ff;

   a_eof_is_cr: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && eof_ff) |-> (last_ff && char_ff == CH_CR))
      else $error("frame end not on the closing carriage return");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (step < total))
      else $error("step past the end of the job");

endmodule

// ----- rtl/six_bit_printable_telemetry_framer.sv -----
// ----------------------------------------------------------------------------
// Six-bit printable telemetry framer
// Top level: front part, job queue and character sequencer.
// ----------------------------------------------------------------------------
// Each sample item produces two or three characters, 'A' plus a six-bit digit,
// with the header OUT before the first sample of a frame of 36 samples and
// ZZZ, line feed, carriage return after its last. Characters leave one per
// cycle through the single character output register while the output is not
// held off. An item thus yields 2 or 3 characters, 5 for a frame opener and 8
// for a frame closer, 104 characters for a frame of 36 items or about 2.9 per
// item. A new item is taken whenever the two-entry job queue has room; the
// output may stall without blocking the input until the queue is full.
// ----------------------------------------------------------------------------
module six_bit_printable_telemetry_framer
   import sbptf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [15:0] req_sample,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last_of_item,
   output logic              rsp_end_of_frame
);

   logic    push;
   job_type push_job;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   sbptf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_full     (q_full),
      .push       (push),
      .job        (push_job)
   );

   sbptf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sbptf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the six-bit printable telemetry framer
// Sends signed samples through the request channel and checks every character
// on the response channel against a cycle-free encoder kept here. A short
// table of corner samples, some with hand-written characters, opens the run;
// random samples over several frames follow, with random gaps on both sides,
// one long response hold-off and a stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_top
   import sbptf_pkg::*;
();

   localparam int N_DIRECTED      = 24;
   localparam int N_RANDOM        = 246;
   localparam int HOLD_OFF_AT     = 40;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int CALM_FROM       = 150;
   localparam int CALM_TO         = 200;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 20;

   // One expected character on the response channel.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       eof;
   } char_exp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_char;
   logic               rsp_last_of_item;
   logic               rsp_end_of_frame;

   six_bit_printable_telemetry_framer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   // Free-running clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Directed samples. A nonzero length means the characters are written out
   // by hand, first character in the most significant byte.
   logic [15:0] dir_sample [N_DIRECTED] = '{
      16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'h7FFF, 16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'h5555,
      16'hAAAA, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF,
      16'hFFFE, 16'h0001, 16'h7FFF, 16'h1234, 16'hEDCB, 16'h8001
   };
   int dir_len [N_DIRECTED] = '{
      5, 3, 3, 2, 3, 3, 2, 3, 3, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
   };
   logic [63:0] dir_txt [N_DIRECTED] = '{
      "OUTAA", "AAA", "AAA",
      {8'd128, 8'd128}, {8'd128, 8'd128, 8'd128}, {8'd128, 8'd128, 8'd128},
      {8'd96, 8'd128}, {8'd127, 8'd65, 8'd65}, {8'd73, 8'd65, 8'd65},
      64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
      64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
   };

   logic [15:0] corner_vals [6] = '{
      16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA
   };

   // Encoder state: position in the group, group index and carried bits.
   phase_type  enc_phase;
   logic [3:0] enc_group;
   logic [3:0] enc_carry;
   logic [7:0] enc_chars [8];
   int         enc_n;
   logic       enc_closes;

   char_exp_type chars_due [$];
   int           errors = 0;
   int           samples_taken = 0;
   int           quiet_cycles = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;

   function automatic void add_char(input logic [7:0] c);
      enc_chars[enc_n] = c;
      enc_n++;
   endfunction

   function automatic void add_digit(input logic [5:0] d);
      add_char(CH_BASE + {2'b00, d});
   endfunction

   // Works out the characters one sample produces and advances the encoder.
   function automatic void encode_sample(input logic [15:0] s);
      enc_n      = 0;
      enc_closes = 1'b0;
      case (enc_phase)
         PH_SECOND: begin
            add_digit({enc_carry, s[15:14]});
            add_digit(s[13:8]);
            add_digit(s[7:2]);
            enc_carry = {2'b00, s[1:0]};
            enc_phase = PH_THIRD;
         end
         PH_THIRD: begin
            add_digit({enc_carry[1:0], s[15:12]});
            add_digit(s[11:6]);
            add_digit(s[5:0]);
            enc_carry = 4'd0;
            enc_phase = PH_FIRST;
            if (int'(enc_group) + 1 >= int'(GROUPS_PER_FRAME)) begin
               add_char(CH_Z);
               add_char(CH_Z);
               add_char(CH_Z);
               add_char(CH_LF);
               add_char(CH_CR);
               enc_closes = 1'b1;
               enc_group  = 4'd0;
            end else begin
               enc_group = enc_group + 4'd1;
            end
         end
         default: begin
            // A phase outside the group is handled as its first sample.
            if (enc_group == 4'd0) begin
               add_char(CH_O);
               add_char(CH_U);
               add_char(CH_T);
            end
            add_digit(s[15:10]);
            add_digit(s[9:4]);
            enc_carry = s[3:0];
            enc_phase = PH_SECOND;
         end
      endcase
   endfunction

   // No gaps on either side while this window of samples goes through.
   function automatic bit calm_window();
      return samples_taken >= CALM_FROM && samples_taken < CALM_TO;
   endfunction

   // Offers one sample, waits for its acceptance and queues its characters.
   task automatic offer_sample(input logic [15:0] s, input int typed_n,
                               input logic [63:0] typed_txt);
      int           i;
      int           n;
      char_exp_type e;
      while (!calm_window() && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      samples_taken++;
      encode_sample(s);
      n = (typed_n == 0) ? enc_n : typed_n;
      for (i = 0; i < n; i++) begin
         e.ch   = (typed_n == 0) ? enc_chars[i] : typed_txt[8 * (n - 1 - i) +: 8];
         e.last = (i == n - 1);
         e.eof  = enc_closes && (i == n - 1);
         chars_due.push_back(e);
      end
      @(negedge clock);
   endtask

   // Response side: random gaps, one long hold-off that fills the block.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && samples_taken >= HOLD_OFF_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (calm_window()) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 33);
      end
   end

   // Compare each accepted character with the oldest one expected.
   always @(posedge clock) begin : check_chars
      char_exp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (chars_due.size() == 0) begin
            $display("%0t: unexpected item, char %0d", $time, rsp_out_char);
            errors++;
         end else begin
            e = chars_due.pop_front();
            if (rsp_out_char !== e.ch) begin
               $display("%0t: out_char expected %0d, got %0d", $time, e.ch, rsp_out_char);
               errors++;
            end
            if (rsp_last_of_item !== e.last) begin
               $display("%0t: last_of_item expected %0b, got %0b",
                        $time, e.last, rsp_last_of_item);
               errors++;
            end
            if (rsp_end_of_frame !== e.eof) begin
               $display("%0t: end_of_frame expected %0b, got %0b",
                        $time, e.eof, rsp_end_of_frame);
               errors++;
            end
         end
      end
   end

   // Ends the run when neither channel has moved an item for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL six_bit_printable_telemetry_framer");
         $finish;
      end
   end

   // Reset, directed table, random samples, then drain and report.
   initial begin
      int          k;
      logic [15:0] s;
      enc_phase = PH_FIRST;
      enc_group = 4'd0;
      enc_carry = 4'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_DIRECTED; k++)
         offer_sample(dir_sample[k], dir_len[k], dir_txt[k]);

      for (k = 0; k < N_RANDOM; k++) begin
         if ($urandom_range(0, 9) == 0)
            s = corner_vals[$urandom_range(0, 5)];
         else
            s = 16'($urandom_range(0, 65535));
         offer_sample(s, 0, 64'd0);
      end
      req_valid <= 1'b0;

      while (chars_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("PASS six_bit_printable_telemetry_framer");
      else
         $display("FAIL six_bit_printable_telemetry_framer");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sbptf_pkg.sv
rtl/sbptf_front.sv
rtl/sbptf_queue.sv
rtl/sbptf_back.sv
rtl/six_bit_printable_telemetry_framer.sv
tb/tb_top.sv
